@@ rtl/core/obstacle_avoid_state_machine_top_defines.svh @@
// Assertion macros for the obstacle avoidance mode machine.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef OBSTACLE_AVOID_STATE_MACHINE_TOP_DEFINES_SVH
`define OBSTACLE_AVOID_STATE_MACHINE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define OAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/oasm_pkg.sv @@
// Shared types and constants for the obstacle avoidance mode machine.
// No dependencies.
package oasm_pkg;

  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_WAIT    = 2'd1,
    MODE_AVOID   = 2'd2,
    MODE_RECHECK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_DETECT_THR   = 3'd0,
    CFG_LOW_COUNT    = 3'd1,
    CFG_DETECT_WAIT  = 3'd2,
    CFG_CLEAR_THR    = 3'd3,
    CFG_RECHECK_THR  = 3'd4,
    CFG_RECHECK_WAIT = 3'd5,
    CFG_LOW_TEXTURE  = 3'd6
  } cfg_reg_e;

  localparam int unsigned CountW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned PersistW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PersistW-1:0] DetectPersist  = 8'd3;
  localparam logic [PersistW-1:0] ClearPersist   = 8'd1;
  localparam logic [PersistW-1:0] RecheckPersist = 8'd1;
  localparam logic [PersistW-1:0] CountMax       = 8'd255;

  localparam logic [CountW-1:0] DetectThrRst   = 16'd55;
  localparam logic [CountW-1:0] LowCountRst    = 16'd10;
  localparam logic [CountW-1:0] DetectWaitRst  = 16'd1800;
  localparam logic [CountW-1:0] ClearThrRst    = 16'd25;
  localparam logic [CountW-1:0] RecheckThrRst  = 16'd25;
  localparam logic [CountW-1:0] RecheckWaitRst = 16'd500;

  function automatic logic [PersistW-1:0] sat_inc(input logic [PersistW-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

endpackage

@@ rtl/core/obstacle_avoid_state_machine_top.sv @@
// Obstacle avoidance mode machine: input register, mode logic, result register.
// Depends on oasm_pkg and obstacle_avoid_state_machine_top_defines.svh.
//
//   channel | handshake                | payload
//   --------+--------------------------+--------------------------------------------
//   in      | in_valid_i / in_stall_o  | total, high, histogram, left, right, now_ms
//   out     | out_valid_o / out_stall_i| mode_out_o
//   cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle when the output does not stall; an accepted item is held in the input
// register, and its mode is written to the result register when that item advances.
// The mode update between the input register and the result register sets that rate.
// Reset puts the mode in recheck and all counters and start time at zero.
// A stall on the output holds the result and then the input register; the input
// register frees as soon as the result register does, in the same cycle.
`include "obstacle_avoid_state_machine_top_defines.svh"

module obstacle_avoid_state_machine_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [oasm_pkg::CountW-1:0]  total_disparities_i,
  input  logic [oasm_pkg::CountW-1:0]  high_disparities_i,
  input  logic [oasm_pkg::CountW-1:0]  obstacle_histogram_i,
  input  logic [oasm_pkg::CountW-1:0]  left_count_i,
  input  logic [oasm_pkg::CountW-1:0]  right_count_i,
  input  logic [oasm_pkg::TimeW-1:0]   now_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   mode_out_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [oasm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [oasm_pkg::CountW-1:0]  cfg_data_i
);
  import oasm_pkg::*;

  // configuration
  logic [CountW-1:0] detect_thr_q, low_count_q, detect_wait_q;
  logic [CountW-1:0] clear_thr_q, recheck_thr_q, recheck_wait_q;
  logic              low_tex_q;

  // input register
  logic              s1_valid_q;
  logic [CountW-1:0] total_q, high_q, hist_q, left_q, right_q;
  logic [TimeW-1:0]  now_q;

  // mode state
  mode_e               mode_q, mode_d;
  logic [PersistW-1:0] detect_cnt_q, detect_cnt_d;
  logic [PersistW-1:0] clear_cnt_q, clear_cnt_d;
  logic [PersistW-1:0] recheck_cnt_q, recheck_cnt_d;
  logic [TimeW-1:0]    start_q, start_d;

  // result register
  logic       out_valid_q;
  logic [1:0] mode_out_q;

  logic             advance;
  logic             in_accept;
  logic [TimeW-1:0] elapsed;
  logic             detect_expired, recheck_expired;
  logic             recheck_hit, safe_hit;
  logic [PersistW-1:0] cnt_tmp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_thr_q   <= DetectThrRst;
      low_count_q    <= LowCountRst;
      detect_wait_q  <= DetectWaitRst;
      clear_thr_q    <= ClearThrRst;
      recheck_thr_q  <= RecheckThrRst;
      recheck_wait_q <= RecheckWaitRst;
      low_tex_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DETECT_THR:   detect_thr_q   <= cfg_data_i;
        CFG_LOW_COUNT:    low_count_q    <= cfg_data_i;
        CFG_DETECT_WAIT:  detect_wait_q  <= cfg_data_i;
        CFG_CLEAR_THR:    clear_thr_q    <= cfg_data_i;
        CFG_RECHECK_THR:  recheck_thr_q  <= cfg_data_i;
        CFG_RECHECK_WAIT: recheck_wait_q <= cfg_data_i;
        CFG_LOW_TEXTURE:  low_tex_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_accept || (s1_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      total_q <= total_disparities_i;
      high_q  <= high_disparities_i;
      hist_q  <= obstacle_histogram_i;
      left_q  <= left_count_i;
      right_q <= right_count_i;
      now_q   <= now_ms_i;
    end
    if (advance) begin
      mode_out_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_RECHECK;
      detect_cnt_q  <= '0;
      clear_cnt_q   <= '0;
      recheck_cnt_q <= '0;
      start_q       <= '0;
    end else if (advance) begin
      mode_q        <= mode_d;
      detect_cnt_q  <= detect_cnt_d;
      clear_cnt_q   <= clear_cnt_d;
      recheck_cnt_q <= recheck_cnt_d;
      start_q       <= start_d;
    end
  end

  // wrapping elapsed time since the last start mark
  assign elapsed         = now_q - start_q;
  assign detect_expired  = elapsed > {{(TimeW-CountW){1'b0}}, detect_wait_q};
  assign recheck_expired = elapsed > {{(TimeW-CountW){1'b0}}, recheck_wait_q};

  assign recheck_hit = (high_q > recheck_thr_q) || (total_q < low_count_q);
  assign safe_hit    = low_tex_q ?
                       (high_q < clear_thr_q) && (left_q > low_count_q) &&
                       (right_q > low_count_q) :
                       (high_q < clear_thr_q) && (total_q > low_count_q);

  always_comb begin
    mode_d        = mode_q;
    detect_cnt_d  = detect_cnt_q;
    clear_cnt_d   = clear_cnt_q;
    recheck_cnt_d = recheck_cnt_q;
    start_d       = start_q;
    cnt_tmp       = '0;
    case (mode_q)
      MODE_FREE: begin
        if (low_tex_q) begin
          if ((hist_q > detect_thr_q) || (left_q < low_count_q) ||
              (right_q < low_count_q)) begin
            mode_d = MODE_AVOID;
          end
        end else begin
          if ((high_q > detect_thr_q) || (total_q < low_count_q)) begin
            cnt_tmp = sat_inc(detect_cnt_q);
          end else if (detect_cnt_q != '0) begin
            cnt_tmp = detect_cnt_q - 1'b1;
          end else begin
            cnt_tmp = detect_cnt_q;
          end
          detect_cnt_d = cnt_tmp;
          if (cnt_tmp > DetectPersist) begin
            mode_d       = MODE_WAIT;
            detect_cnt_d = '0;
            start_d      = now_q;
          end
        end
      end
      MODE_WAIT: begin
        if (detect_expired) begin
          mode_d = MODE_AVOID;
        end
      end
      MODE_AVOID: begin
        cnt_tmp     = safe_hit ? sat_inc(clear_cnt_q) : '0;
        clear_cnt_d = cnt_tmp;
        if (cnt_tmp > ClearPersist) begin
          mode_d      = MODE_RECHECK;
          clear_cnt_d = '0;
          start_d     = now_q;
        end
      end
      default: begin
        cnt_tmp       = recheck_hit ? sat_inc(recheck_cnt_q) : '0;
        recheck_cnt_d = cnt_tmp;
        if (cnt_tmp > RecheckPersist) begin
          mode_d        = MODE_AVOID;
          recheck_cnt_d = '0;
        end else if (recheck_expired) begin
          mode_d        = MODE_FREE;
          recheck_cnt_d = '0;
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign mode_out_o  = mode_out_q;

  // wait mode is entered only from unobstructed under normal rules
  `OAS_ASSERT_IMP(a_wait_entry, advance && mode_d == MODE_WAIT && mode_q != MODE_WAIT, mode_q == MODE_FREE && !low_tex_q, "wait mode entered from wrong mode")
  // persistence counters clear as soon as they pass their limit
  `OAS_ASSERT_IMP(a_cnt_bound, 1'b1, detect_cnt_q <= DetectPersist && clear_cnt_q <= ClearPersist && recheck_cnt_q <= RecheckPersist, "persistence counter past its limit")
  // an item leaving the input register shows up at the output
  `OAS_ASSERT_NXT(a_adv_out, advance, out_valid_o && mode_out_o == mode_q, "advanced item missing at output")
  // low-texture rules never touch the detection counter
  `OAS_ASSERT_NXT(a_lt_detect, advance && low_tex_q && mode_q == MODE_FREE, detect_cnt_q == $past(detect_cnt_q), "detection counter moved under low-texture rules")

endmodule

@@ tb/tb_obstacle_avoid_state_machine_top.sv @@
// Testbench for obstacle_avoid_state_machine_top: random and directed frames with a
// cycle-free mode predictor, random idling on both channels and register phases.
// Depends on oasm_pkg and the top-level RTL only.
module tb_obstacle_avoid_state_machine_top;
  import oasm_pkg::*;

  localparam int unsigned LimitCycles = 400000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct packed {
    logic [CountW-1:0] total;
    logic [CountW-1:0] high;
    logic [CountW-1:0] hist;
    logic [CountW-1:0] left;
    logic [CountW-1:0] right;
    logic [TimeW-1:0]  now;
  } frame_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CountW-1:0]   total_disparities_i = '0;
  logic [CountW-1:0]   high_disparities_i = '0;
  logic [CountW-1:0]   obstacle_histogram_i = '0;
  logic [CountW-1:0]   left_count_i = '0;
  logic [CountW-1:0]   right_count_i = '0;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          mode_out_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CountW-1:0]   cfg_data_i = '0;

  // Register copies, shared by the frame shaper and the mode predictor
  logic [CountW-1:0] thr_detect = DetectThrRst;
  logic [CountW-1:0] thr_low = LowCountRst;
  logic [CountW-1:0] wait_detect = DetectWaitRst;
  logic [CountW-1:0] thr_clear = ClearThrRst;
  logic [CountW-1:0] thr_recheck = RecheckThrRst;
  logic [CountW-1:0] wait_recheck = RecheckWaitRst;
  logic              low_texture = 1'b0;

  // Predicted machine state
  mode_e               track_mode = MODE_RECHECK;
  logic [PersistW-1:0] detect_cnt = '0;
  logic [PersistW-1:0] clear_cnt = '0;
  logic [PersistW-1:0] recheck_cnt = '0;
  logic [TimeW-1:0]    t_start = '0;

  frame_t frame_q[$];
  mode_e  mode_expect_q[$];
  int     frames_queued = 0;
  int     modes_checked = 0;
  int     mismatch_count = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     tick_max = 100;
  logic [TimeW-1:0] clock_ms = '0;

  obstacle_avoid_state_machine_top uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .total_disparities_i  (total_disparities_i),
    .high_disparities_i   (high_disparities_i),
    .obstacle_histogram_i (obstacle_histogram_i),
    .left_count_i         (left_count_i),
    .right_count_i        (right_count_i),
    .now_ms_i             (now_ms_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .mode_out_o           (mode_out_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Mode after one frame, updating the predicted state
  function automatic mode_e advance_mode(input frame_t f);
    logic [TimeW-1:0] elapsed;
    logic             safe;
    elapsed = f.now - t_start;
    case (track_mode)
      MODE_FREE: begin
        if (low_texture) begin
          if (f.hist > thr_detect || f.left < thr_low || f.right < thr_low)
            track_mode = MODE_AVOID;
        end else begin
          if (f.high > thr_detect || f.total < thr_low) begin
            if (detect_cnt != CountMax) detect_cnt++;
          end else if (detect_cnt != '0) begin
            detect_cnt--;
          end
          if (detect_cnt > DetectPersist) begin
            track_mode = MODE_WAIT;
            detect_cnt = '0;
            t_start = f.now;
          end
        end
      end
      MODE_WAIT: begin
        // No low-texture rule here: the timer alone moves on
        if (elapsed > wait_detect) track_mode = MODE_AVOID;
      end
      MODE_AVOID: begin
        if (low_texture)
          safe = f.high < thr_clear && f.left > thr_low && f.right > thr_low;
        else
          safe = f.high < thr_clear && f.total > thr_low;
        if (!safe) clear_cnt = '0;
        else if (clear_cnt != CountMax) clear_cnt++;
        if (clear_cnt > ClearPersist) begin
          track_mode = MODE_RECHECK;
          clear_cnt = '0;
          t_start = f.now;
        end
      end
      default: begin
        if (f.high > thr_recheck || f.total < thr_low) begin
          if (recheck_cnt != CountMax) recheck_cnt++;
        end else begin
          recheck_cnt = '0;
        end
        if (recheck_cnt > RecheckPersist) begin
          track_mode = MODE_AVOID;
          recheck_cnt = '0;
        end else if (elapsed > wait_recheck) begin
          track_mode = MODE_FREE;
          recheck_cnt = '0;
        end
      end
    endcase
    return track_mode;
  endfunction

  // Value at most hi, mostly close to it
  function automatic logic [CountW-1:0] pick_upto(input int hi);
    int lo;
    if (hi < 0) return '0;
    if (hi > 65535) hi = 65535;
    lo = ($urandom_range(9) < 7 && hi > 63) ? hi - 63 : 0;
    return CountW'($urandom_range(hi, lo));
  endfunction

  // Value at least lo, mostly close to it
  function automatic logic [CountW-1:0] pick_from(input int lo);
    int hi;
    if (lo > 65535) return '1;
    if (lo < 0) lo = 0;
    hi = ($urandom_range(9) < 7 && lo < 65472) ? lo + 63 : 65535;
    return CountW'($urandom_range(hi, lo));
  endfunction

  task automatic queue_frame(input logic [CountW-1:0] total, input logic [CountW-1:0] high,
                             input logic [CountW-1:0] hist, input logic [CountW-1:0] left,
                             input logic [CountW-1:0] right, input logic [TimeW-1:0] now);
    frame_t f;
    f = '{total: total, high: high, hist: hist, left: left, right: right, now: now};
    frame_q.push_back(f);
    frames_queued++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DETECT_THR:   thr_detect = data;
      CFG_LOW_COUNT:    thr_low = data;
      CFG_DETECT_WAIT:  wait_detect = data;
      CFG_CLEAR_THR:    thr_clear = data;
      CFG_RECHECK_THR:  thr_recheck = data;
      CFG_RECHECK_WAIT: wait_recheck = data;
      CFG_LOW_TEXTURE:  low_texture = data[0];
      default: ;
    endcase
  endtask

  // Hold until every expected mode has come back, then let the pipeline settle
  task automatic wait_idle();
    while (modes_checked < frames_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_frames
    frame_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        mode_expect_q.push_back(advance_mode('{total: total_disparities_i,
            high: high_disparities_i, hist: obstacle_histogram_i, left: left_count_i,
            right: right_count_i, now: now_ms_i}));
      // Advance only when the current item is gone; a stalled item holds
      if (!in_valid_i || !in_stall_o) begin
        if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = frame_q.pop_front();
          in_valid_i           <= 1'b1;
          total_disparities_i  <= nxt.total;
          high_disparities_i   <= nxt.high;
          obstacle_histogram_i <= nxt.hist;
          left_count_i         <= nxt.left;
          right_count_i        <= nxt.right;
          now_ms_i             <= nxt.now;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_modes
    mode_e want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (mode_expect_q.size() == 0) begin
          report_mismatch($sformatf("mode %0d arrived with nothing pending", mode_out_o));
        end else begin
          want = mode_expect_q.pop_front();
          modes_checked++;
          if (mode_out_o !== want)
            report_mismatch($sformatf("mode_out got %0d, expected %0d (%s)",
                                      mode_out_o, want, want.name()));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #(LimitCycles * 12);
    $display("** obstacle_avoid_state_machine_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int k;
    int n_items;
    int run_left;
    int hmax;
    logic obstacle_run;
    logic [CountW-1:0] f_total, f_high, f_hist, f_left, f_right;
    logic [CountW-1:0] set_detect, set_low, set_dwait, set_clear;
    logic [CountW-1:0] set_recheck, set_rwait, set_lt;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 47;

    // Walk every mode under the reset registers, timer edges included
    queue_frame(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    queue_frame(16'd100, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 32'd500);   // timer equal
    queue_frame(16'd100, 16'd0, 16'd0, 16'hFFFF, 16'd0, 32'd501);      // timer expired
    queue_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_frame(16'd100, 16'd55, 16'd0, 16'd0, 16'd0, 32'd600);        // level at threshold
    queue_frame(16'd100, 16'd56, 16'd0, 16'd0, 16'd0, 32'd700);
    queue_frame(16'd100, 16'd56, 16'd0, 16'd0, 16'd0, 32'd800);
    queue_frame(16'd100, 16'd56, 16'd0, 16'd0, 16'd0, 32'd900);
    queue_frame(16'd100, 16'd56, 16'd0, 16'd0, 16'd0, 32'd1000);       // enter wait
    queue_frame(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 32'd2800);
    queue_frame(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 32'd2801);        // enter avoid
    queue_frame(16'd11, 16'd24, 16'd0, 16'd0, 16'd0, 32'd2900);
    queue_frame(16'd11, 16'd25, 16'd0, 16'd0, 16'd0, 32'd3000);        // not safe, clear
    queue_frame(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 32'd4000);
    queue_frame(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 32'd5000);       // enter recheck
    queue_frame(16'd100, 16'd26, 16'd0, 16'd0, 16'd0, 32'd5100);
    queue_frame(16'd100, 16'd26, 16'd0, 16'd0, 16'd0, 32'd5150);       // back to avoid
    queue_frame(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 32'd5200);
    queue_frame(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 32'd5300);
    queue_frame(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 32'd5801);        // unobstructed
    queue_frame(16'd5, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd6000);
    queue_frame(16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 32'd6100);
    queue_frame(16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 32'd6200);
    queue_frame(16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 32'd6300);          // left in wait
    clock_ms = 32'd6300;
    run_left = 0;
    obstacle_run = 1'b0;

    for (phase = 1; phase <= 8; phase++) begin
      wait_idle();
      if (phase >= 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (phase >= 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 27;
      end
      case (phase)
        1: begin
          // Low-texture rules switched on while the machine waits
          set_detect = DetectThrRst;
          set_low = LowCountRst;
          set_dwait = DetectWaitRst;
          set_clear = ClearThrRst;
          set_recheck = RecheckThrRst;
          set_rwait = RecheckWaitRst;
          set_lt = 16'd1;
        end
        2: begin
          set_detect = '0;
          set_low = '0;
          set_dwait = '0;
          set_clear = '0;
          set_recheck = '0;
          set_rwait = '0;
          set_lt = '0;
        end
        3: begin
          set_detect = '1;
          set_low = '1;
          set_dwait = '1;
          set_clear = '1;
          set_recheck = '1;
          set_rwait = '1;
          set_lt = '1;
        end
        default: begin
          set_detect = CountW'($urandom_range(200));
          set_low = CountW'($urandom_range(60));
          set_dwait = CountW'($urandom_range(3000));
          set_clear = CountW'($urandom_range(120));
          set_recheck = CountW'($urandom_range(120));
          set_rwait = CountW'($urandom_range(2000));
          // Upper data bits must not reach the mode select
          set_lt = {15'($urandom()), phase[0]};
        end
      endcase
      write_reg(CFG_DETECT_THR, set_detect);
      write_reg(CFG_LOW_COUNT, set_low);
      write_reg(CFG_DETECT_WAIT, set_dwait);
      write_reg(CFG_CLEAR_THR, set_clear);
      write_reg(CFG_RECHECK_THR, set_recheck);
      write_reg(CFG_RECHECK_WAIT, set_rwait);
      write_reg(CFG_LOW_TEXTURE, set_lt);
      if (phase == 7) write_reg(CfgUnused, CountW'($urandom()));

      tick_max = ((wait_detect > wait_recheck) ? int'(wait_detect) : int'(wait_recheck)) / 3
                 + 20;
      n_items = (phase == 2 || phase == 3) ? 120 : 280;

      for (k = 0; k < n_items; k++) begin
        // Runs of obstacle frames and clear frames, the kind of each run picked at random
        if (run_left == 0) begin
          obstacle_run = 1'($urandom_range(1));
          run_left = $urandom_range(14, 2);
        end
        run_left--;
        if ($urandom_range(99) < 3) clock_ms = $urandom();
        else clock_ms += $urandom_range(tick_max);

        if ($urandom_range(99) < 12) begin
          queue_frame(CountW'($urandom()), CountW'($urandom()), CountW'($urandom()),
                      CountW'($urandom()), CountW'($urandom()), clock_ms);
        end else begin
          hmax = int'(thr_clear) - 1;
          if (int'(thr_recheck) < hmax) hmax = int'(thr_recheck);
          if (int'(thr_detect) < hmax) hmax = int'(thr_detect);
          f_high = pick_upto(hmax);
          f_total = pick_from(int'(thr_low) + 1);
          f_hist = pick_upto(int'(thr_detect));
          f_left = pick_from(int'(thr_low) + 1);
          f_right = pick_from(int'(thr_low) + 1);
          if (obstacle_run) begin
            case ($urandom_range(4))
              0: f_high = pick_from(((thr_detect > thr_recheck) ? int'(thr_detect)
                                                                : int'(thr_recheck)) + 1);
              1: f_total = pick_upto(int'(thr_low) - 1);
              2: f_hist = pick_from(int'(thr_detect) + 1);
              3: f_left = pick_upto(int'(thr_low) - 1);
              default: f_right = pick_upto(int'(thr_low) - 1);
            endcase
          end
          queue_frame(f_total, f_high, f_hist, f_left, f_right, clock_ms);
        end
      end
    end

    wait_idle();
    if (mode_expect_q.size() != 0)
      report_mismatch($sformatf("%0d expected modes never arrived", mode_expect_q.size()));
    if (mismatch_count == 0) begin
      $display("** obstacle_avoid_state_machine_top: PASSED **");
    end else begin
      $display("** obstacle_avoid_state_machine_top: FAILED **");
    end
    $finish;
  end

endmodule
